// ----- design/lpc_pkg.sv -----
// lpc_pkg: shared widths, register map codes and reset values for the
// line position centroid estimator and its port checker
// no dependencies
package lpc_pkg;

  // default depth of one frame of samples
  localparam int unsigned MAX_SENSORS_DEF = 8;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned POS_W    = 20;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned GATE_W   = 16;

  // apb port
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;

  // register indexes (byte address 4*index)
  localparam logic [REG_IDX_W-1:0] REG_FRAME_LEN    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_UM     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NOISE_GATE   = 2'd2;

  // register reset values
  localparam logic [COUNT_W-1:0] COUNT_RST = 4'd4;
  localparam logic [PITCH_W-1:0] PITCH_RST = 16'd10000;
  localparam logic [GATE_W-1:0]  GATE_RST  = 16'd3277;

  // saturation limits of the position result
  localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;

endpackage

// ----- design/line_position_centroid.sv -----
// line_position_centroid: per-sample accept and gated weight sum, a shift-add
// multiply and a restoring divide that share one adder/subtractor
// depends on lpc_pkg
//
// operation: a sample is taken only while idle, then multiplied shift-add, lsb
// first, until the rest of its gated weight is zero (at once when it is gated
// out); the last sample of a frame then adds a sign prep step, the restoring
// divide and a fix-up step (both skipped when nothing passed the gate), then
// the load of the output register
// throughput: one sample at a time, set by the shared adder loop, plus any
// wait for the output register to free up
// reset: async active low; clears sums, index, held position, output valid and
// restores frame length 4, pitch 10000 um, noise gate 3277
module line_position_centroid #(
  parameter int unsigned MAX_SENSORS = lpc_pkg::MAX_SENSORS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // apb-style configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpc_pkg::APB_AW-1:0]         paddr,
  input  logic [lpc_pkg::APB_DW-1:0]         pwdata,
  output logic [lpc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  // sample input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lpc_pkg::SAMPLE_W-1:0]       sample_weight_i,
  // position output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lpc_pkg::POS_W-1:0]   position_half_um_o,
  output logic                               line_seen_o
);
  import lpc_pkg::*;

  // index of a sensor inside a frame
  localparam int unsigned IDX_W  = $clog2(MAX_SENSORS);
  // effective sensor count, 1..MAX_SENSORS
  localparam int unsigned CNT_W  = $clog2(MAX_SENSORS + 1);
  localparam int unsigned CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  // signed sensor offset (count-1-2*idx) in pitch/2 units
  localparam int unsigned OFF_W  = CNT_W + 2;
  // signed sensor position in half-micrometres
  localparam int unsigned PP_W   = OFF_W + PITCH_W + 1;
  // gated weight sum and signed position-weighted sum
  localparam int unsigned WSUM_W = SAMPLE_W + IDX_W;
  localparam int unsigned PSUM_W = 2 * SAMPLE_W + 1 + 2 * IDX_W;
  // shared adder width, one extra bit for the borrow of a divide step
  localparam int unsigned AW     = PSUM_W + 1;
  localparam int unsigned DC_W   = $clog2(PSUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [COUNT_W-1:0] count_cfg_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [GATE_W-1:0]  gate_q;

  // frame state
  logic [IDX_W-1:0]         idx_q;
  logic                     last_q;
  logic [WSUM_W-1:0]        wsum_q;
  logic signed [PSUM_W-1:0] psum_q;
  logic signed [POS_W-1:0]  held_q;

  // output register
  logic                     out_valid_q;
  logic signed [POS_W-1:0]  out_pos_q;
  logic                     out_seen_q;

  // datapath of the shared unit
  logic signed [PSUM_W-1:0] mc_q;      // multiplicand, shifted left each step
  logic [SAMPLE_W-1:0]      mplr_q;    // multiplier bits, consumed lsb first
  logic [PSUM_W-1:0]        dvd_q;     // dividend magnitude, becomes quotient
  logic [WSUM_W-1:0]        rem_q;     // partial remainder
  logic [DC_W-1:0]          div_cnt_q;
  logic                     neg_q;
  logic signed [POS_W-1:0]  res_pos_q;
  logic                     res_seen_q;

  // apb decode
  logic                 apb_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign apb_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_LEN:    prdata = APB_DW'(count_cfg_q);
      REG_PITCH_UM:     prdata = APB_DW'(pitch_q);
      REG_NOISE_GATE:   prdata = APB_DW'(gate_q);
      default:          prdata = '0;
    endcase
  end

  // handshakes
  logic in_accept;
  assign in_ready_o         = (state_q == ST_IDLE);
  assign in_accept          = in_valid_i && in_ready_o;
  assign out_valid_o        = out_valid_q;
  assign position_half_um_o = out_pos_q;
  assign line_seen_o        = out_seen_q;

  // effective count: zero reads as one, large values clamp to the array size
  logic [CNT_W-1:0] eff_cnt;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_eff;
  logic             is_last;
  logic             gate_pass;
  logic [OFF_W-1:0] offset;
  logic signed [PP_W-1:0] pos_prod;

  always_comb begin
    if (count_cfg_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (CMP_W'(count_cfg_q) > CMP_W'(MAX_SENSORS)) begin
      eff_cnt = CNT_W'(MAX_SENSORS);
    end else begin
      eff_cnt = CNT_W'(count_cfg_q);
    end
  end

  // count lowered mid-frame: the current sample closes the frame
  assign idx_ext   = CNT_W'(idx_q);
  assign idx_eff   = (idx_ext >= eff_cnt) ? (eff_cnt - CNT_W'(1)) : idx_ext;
  assign is_last   = ((idx_eff + CNT_W'(1)) == eff_cnt);
  assign gate_pass = (sample_weight_i > gate_q);

  // sensor position, positive toward sensor zero
  assign offset   = OFF_W'(eff_cnt) - OFF_W'(1) - (OFF_W'(idx_eff) << 1);
  assign pos_prod = $signed(offset) * $signed({1'b0, pitch_q});

  // shared adder/subtractor: accumulate in multiply, trial subtract in divide,
  // negate before and after the divide
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_sub;
  logic [AW-1:0] alu_y;

  logic [WSUM_W:0] div_shift;
  logic            div_borrow;

  assign div_shift = {rem_q, dvd_q[PSUM_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_MUL: begin
        alu_a = {psum_q[PSUM_W-1], psum_q};
        alu_b = {mc_q[PSUM_W-1], mc_q};
      end
      ST_PREP: begin
        alu_b   = {psum_q[PSUM_W-1], psum_q};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = AW'(div_shift);
        alu_b   = AW'(wsum_q);
        alu_sub = 1'b1;
      end
      ST_FIX: begin
        alu_b   = {1'b0, dvd_q};
        alu_sub = neg_q;
      end
      default: begin
      end
    endcase
  end

  assign alu_y      = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
  assign div_borrow = alu_y[AW-1];

  // signed quotient, saturated to the 20-bit result
  logic                    fits;
  logic signed [POS_W-1:0] fix_pos;

  assign fits    = (&alu_y[AW-1:POS_W-1]) || (~|alu_y[AW-1:POS_W-1]);
  assign fix_pos = fits ? $signed(alu_y[POS_W-1:0]) :
                   (alu_y[AW-1] ? POS_MIN : POS_MAX);

  // sequencer, configuration and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_cfg_q <= COUNT_RST;
      pitch_q     <= PITCH_RST;
      gate_q      <= GATE_RST;
      idx_q       <= '0;
      last_q      <= 1'b0;
      wsum_q      <= '0;
      psum_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_seen_q  <= 1'b0;
    end else begin
      if (apb_wr) begin
        unique case (reg_idx)
          REG_FRAME_LEN:    count_cfg_q <= pwdata[COUNT_W-1:0];
          REG_PITCH_UM:     pitch_q     <= pwdata[PITCH_W-1:0];
          REG_NOISE_GATE:   gate_q      <= pwdata[GATE_W-1:0];
          default: begin
          end
        endcase
      end

      // the output state reloads the register itself
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            idx_q   <= is_last ? '0 : IDX_W'(idx_eff + CNT_W'(1));
            last_q  <= is_last;
            if (gate_pass) begin
              wsum_q <= wsum_q + WSUM_W'(sample_weight_i);
            end
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // multiplier exhausted: product is in the sum
          if (mplr_q == '0) begin
            state_q <= last_q ? ST_PREP : ST_IDLE;
          end else if (mplr_q[0]) begin
            psum_q <= alu_y[PSUM_W-1:0];
          end
        end
        ST_PREP: begin
          // nothing passed the gate: repeat the held position
          state_q <= (wsum_q == '0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (div_cnt_q == '0) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          held_q  <= fix_pos;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // wait for the output register to free up
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_pos_q   <= res_pos_q;
            out_seen_q  <= res_seen_q;
            wsum_q      <= '0;
            psum_q      <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // shift registers of the multiply and divide loops
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mc_q   <= {{(PSUM_W - PP_W){pos_prod[PP_W-1]}}, pos_prod};
          mplr_q <= gate_pass ? sample_weight_i : '0;
        end
      end
      ST_MUL: begin
        mc_q   <= mc_q <<< 1;
        mplr_q <= mplr_q >> 1;
      end
      ST_PREP: begin
        // divide magnitudes, sign restored in the fix-up step
        neg_q      <= psum_q[PSUM_W-1];
        dvd_q      <= psum_q[PSUM_W-1] ? alu_y[PSUM_W-1:0] : psum_q;
        rem_q      <= '0;
        div_cnt_q  <= DC_W'(PSUM_W - 1);
        res_pos_q  <= held_q;
        res_seen_q <= 1'b0;
      end
      ST_DIV: begin
        // restoring step, one quotient bit per cycle
        if (div_borrow) begin
          rem_q <= div_shift[WSUM_W-1:0];
        end else begin
          rem_q <= alu_y[WSUM_W-1:0];
        end
        dvd_q     <= {dvd_q[PSUM_W-2:0], ~div_borrow};
        div_cnt_q <= div_cnt_q - DC_W'(1);
      end
      ST_FIX: begin
        res_pos_q  <= fix_pos;
        res_seen_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/lpc_checker.sv -----
// lpc_checker: port-level assertions for the line position centroid estimator,
// bound to the top level below
// depends on lpc_pkg and line_position_centroid
module lpc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [lpc_pkg::POS_W-1:0] position_half_um_o,
  input logic                             line_seen_o
);
  import lpc_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_half_um_o)
      && $stable(line_seen_o))
    else $error("output transaction changed while stalled");

  // an accepted sample leaves the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an input transaction");

  // a new result only appears after the block was busy finishing a frame
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the block was idle");

  // no result is shown while reset is asserted
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind line_position_centroid lpc_checker u_lpc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .position_half_um_o (position_half_um_o),
  .line_seen_o        (line_seen_o)
);

// ----- bench/tb_line_position_centroid.sv -----
// tb_line_position_centroid: self-checking bench for the line position centroid
// estimator, with a scoreboard class that predicts each frame's position result
// depends on lpc_pkg and line_position_centroid
module tb_line_position_centroid;
  timeunit 1ns;
  timeprecision 1ps;

  import lpc_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS  = 400;
  // the last stretch of random samples runs with no idling on either side
  localparam int unsigned QUIET_FROM    = 340;
  localparam int unsigned HOLD_PHASE    = 3;
  localparam int unsigned HOLD_CYCLES   = 300;
  // run limit in ns, well beyond the slowest correct run
  localparam int unsigned RUN_LIMIT_NS  = 4_000_000;

  // no register lives at this index, writes to it must be dropped
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [SAMPLE_W-1:0]       sample_weight_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [POS_W-1:0]   position_half_um_o;
  logic                      line_seen_o;

  // handshakes between the sample process and the position receiver
  logic                      quiet;
  logic                      hold_off_req;
  logic                      hold_off_taken;
  int unsigned               n_cfg_writes;

  // one expected position transaction
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             seen;
  } line_fix_t;

  // centroid predictor plus the queue of positions still owed by the block
  class centroid_scoreboard;
    logic [COUNT_W-1:0] count_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [GATE_W-1:0]  gate_reg;
    int unsigned        elem_idx;
    longint             weight_sum;
    longint             moment_sum;
    logic [POS_W-1:0]   held_pos;
    line_fix_t          fix_q[$];
    int unsigned        n_errors;
    int unsigned        n_samples;
    int unsigned        n_lit;
    int unsigned        n_dark;

    function void reset_state();
      count_reg  = COUNT_RST;
      pitch_reg  = PITCH_RST;
      gate_reg   = GATE_RST;
      elem_idx   = 0;
      weight_sum = 0;
      moment_sum = 0;
      held_pos   = '0;
      fix_q.delete();
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
      case (idx)
        REG_FRAME_LEN:    count_reg = val[COUNT_W-1:0];
        REG_PITCH_UM:     pitch_reg = val[PITCH_W-1:0];
        REG_NOISE_GATE:   gate_reg  = val[GATE_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted sample: gate, accumulate, and close the frame when due
    function void note_sample(logic [SAMPLE_W-1:0] w);
      int unsigned len;
      int unsigned slot;
      longint      wl;
      longint      offset;
      longint      q;
      line_fix_t   fix;
      len = (count_reg == 0) ? 1 :
            (count_reg > MAX_SENSORS_DEF) ? MAX_SENSORS_DEF : count_reg;
      // a count lowered mid-frame makes this sample the frame's last one
      slot = (elem_idx >= len) ? len - 1 : elem_idx;
      n_samples++;
      if (w > gate_reg) begin
        wl = w;
        offset = longint'(len) - 1 - 2 * longint'(slot);
        weight_sum += wl;
        moment_sum += wl * offset * longint'(pitch_reg);
      end
      if (slot + 1 < len) begin
        elem_idx = slot + 1;
        return;
      end
      if (weight_sum > 0) begin
        q = moment_sum / weight_sum;
        if (q > POS_MAX) q = POS_MAX;
        if (q < POS_MIN) q = POS_MIN;
        held_pos = q[POS_W-1:0];
        fix.seen = 1'b1;
        n_lit++;
      end else begin
        fix.seen = 1'b0;
        n_dark++;
      end
      fix.pos = held_pos;
      fix_q.push_back(fix);
      elem_idx   = 0;
      weight_sum = 0;
      moment_sum = 0;
    endfunction

    function void check_result(logic [POS_W-1:0] pos, logic seen);
      line_fix_t want;
      if (fix_q.size() == 0) begin
        $display("%0t: position with nothing owed, actual pos %0d seen %0b",
                 $time, $signed(pos), seen);
        n_errors++;
        return;
      end
      want = fix_q.pop_front();
      if (pos !== want.pos) begin
        $display("%0t: position_half_um expected %0d actual %0d",
                 $time, $signed(want.pos), $signed(pos));
        n_errors++;
      end
      if (seen !== want.seen) begin
        $display("%0t: line_seen expected %0b actual %0b", $time, want.seen, seen);
        n_errors++;
      end
    endfunction
  endclass

  centroid_scoreboard sb;

  line_position_centroid u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_weight_i    (sample_weight_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .position_half_um_o (position_half_um_o),
    .line_seen_o        (line_seen_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // position monitor: outputs are read at the rising edge, before any flop update
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(position_half_um_o, line_seen_o);
    end
  end

  // position receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned burst;
    out_ready_i    = 1'b0;
    hold_off_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_taken) begin
        // long stall so the output register fills and the sample input backs up
        hold_off_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // run limit, in case the block stops answering
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_line_position_centroid: errors");
    $finish;
  end

  // offer one sample, optionally after an idle burst, and wait until taken
  task automatic send_sample(logic [SAMPLE_W-1:0] w);
    int unsigned gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_weight_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(w);
  endtask

  // apb write: setup cycle, then access cycle; pready is tied high
  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    n_cfg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, collect every owed position, then let an inner sample finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.fix_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // weight picker: dark frames stay at or below the gate, others hit the
  // extremes, the gate boundary, or anything at all
  function automatic logic [SAMPLE_W-1:0] pick_weight(logic dark,
                                                      logic [GATE_W-1:0] gate);
    int near;
    if (dark) return SAMPLE_W'($urandom_range(0, gate));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: begin
        near = int'(gate) + int'($urandom_range(0, 2)) - 1;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        return SAMPLE_W'(near);
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // main sequence: reset, directed frames, then random config phases
  initial begin
    int unsigned       n_random;
    int unsigned       phase;
    int unsigned       phase_len;
    logic              dark;
    logic [APB_DW-1:0] val;

    sb = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sample_weight_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    quiet           = 1'b0;
    hold_off_req    = 1'b0;
    n_cfg_writes    = 0;
    dark            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    sb.reset_state();

    // reset settings: a dark frame returns the held reset position of zero
    repeat (4) send_sample('0);
    // full-scale sensor 0, a weight exactly at the gate (ignored), one just above
    send_sample('1);
    send_sample('0);
    send_sample(GATE_RST);
    send_sample(GATE_RST + 16'd1);
    settle();

    // count zero acts as one sensor at the centre; gate zero still blocks zero
    cfg_write(REG_FRAME_LEN, 32'd0);
    cfg_write(REG_NOISE_GATE, 32'd0);
    cfg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_sample('0);
    send_sample('1);
    settle();

    // count above the maximum clamps to eight; only sensor 0 clears the gate
    cfg_write(REG_FRAME_LEN, 32'd15);
    cfg_write(REG_PITCH_UM, 32'd65535);
    cfg_write(REG_NOISE_GATE, 32'd65534);
    send_sample('1);
    repeat (7) send_sample(16'd65534);
    settle();

    // count lowered mid-frame: five of eight sent, then count drops to three
    cfg_write(REG_FRAME_LEN, 32'd8);
    cfg_write(REG_PITCH_UM, 32'd1);
    cfg_write(REG_NOISE_GATE, 32'd0);
    repeat (5) send_sample(SAMPLE_W'($urandom));
    settle();
    cfg_write(REG_FRAME_LEN, 32'd3);
    send_sample('1);
    settle();

    // random phases, each with its own register settings
    n_random = 0;
    phase    = 0;
    while (n_random < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        val = $urandom;
        case ($urandom_range(0, 5))
          0: val[COUNT_W-1:0] = 4'd0;
          1: val[COUNT_W-1:0] = 4'd1;
          2: val[COUNT_W-1:0] = 4'd8;
          3: val[COUNT_W-1:0] = 4'd15;
          4: val[COUNT_W-1:0] = COUNT_W'($urandom_range(9, 15));
          default: val[COUNT_W-1:0] = COUNT_W'($urandom_range(2, 7));
        endcase
        cfg_write(REG_FRAME_LEN, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        val = $urandom;
        case ($urandom_range(0, 4))
          0: val[PITCH_W-1:0] = 16'd1;
          1: val[PITCH_W-1:0] = 16'd65535;
          2: val[PITCH_W-1:0] = 16'd50000;
          default: val[PITCH_W-1:0] = PITCH_W'($urandom_range(0, 65535));
        endcase
        cfg_write(REG_PITCH_UM, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        val = $urandom;
        case ($urandom_range(0, 7))
          0, 1: val[GATE_W-1:0] = 16'd0;
          2: val[GATE_W-1:0] = 16'd65535;
          3: val[GATE_W-1:0] = GATE_RST;
          default: val[GATE_W-1:0] = GATE_W'($urandom_range(0, 65535));
        endcase
        cfg_write(REG_NOISE_GATE, val);
      end
      if ($urandom_range(0, 7) == 0) cfg_write(REG_UNMAPPED, $urandom);

      if (phase == HOLD_PHASE) begin
        // one sensor per frame so every sample owes a position during the hold
        cfg_write(REG_FRAME_LEN, 32'd1);
        hold_off_req = 1'b1;
        phase_len = 40;
      end else begin
        phase_len = $urandom_range(8, 40);
      end
      if (n_random >= QUIET_FROM) quiet = 1'b1;

      repeat (phase_len) begin
        if (sb.elem_idx == 0) dark = ($urandom_range(0, 4) == 0);
        send_sample(pick_weight(dark, sb.gate_reg));
        n_random++;
      end
      settle();
      phase++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d samples over %0d config phases and %0d register writes",
             sb.n_samples, phase, n_cfg_writes);
    $display("frames closed: %0d with a line, %0d dark", sb.n_lit, sb.n_dark);
    if (sb.n_errors == 0) begin
      $display("tb_line_position_centroid: clean");
    end else begin
      $display("tb_line_position_centroid: errors");
    end
    $finish;
  end

endmodule
